FILE: hdl/mdf_pkg.sv
package mdf_pkg;

  localparam int unsigned BinW         = 16;
  localparam int unsigned NumDigits    = 5;
  localparam int unsigned BcdW         = 4 * NumDigits;
  localparam int unsigned AccW         = BcdW + BinW;
  localparam int unsigned StepsPerStage = 4;
  localparam int unsigned NumStages    = BinW / StepsPerStage;

  localparam logic [2:0] MODE_DUAL   = 3'd0;
  localparam logic [2:0] MODE_ONLY_V = 3'd1;
  localparam logic [2:0] MODE_ONLY_A = 3'd2;
  localparam logic [2:0] MODE_SET_V1 = 3'd3;
  localparam logic [2:0] MODE_SET_V2 = 3'd4;
  localparam logic [2:0] MODE_SET_A1 = 3'd5;
  localparam logic [2:0] MODE_SET_A2 = 3'd6;

  localparam logic [4:0] POINT_OFFSET = 5'd10;
  localparam logic [4:0] GLYPH_V      = 5'd20;
  localparam logic [4:0] GLYPH_A      = 5'd21;
  localparam logic [4:0] GLYPH_LABEL  = 5'd22;
  localparam logic [4:0] CODE_ONE     = 5'd1;
  localparam logic [4:0] CODE_TWO     = 5'd2;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] volt_mv;
    logic [15:0] amp_ma;
  } mdf_in_t;

  typedef struct packed {
    logic [4:0] digit0;
    logic [4:0] digit1;
    logic [4:0] digit2;
    logic [4:0] digit3;
    logic [4:0] digit4;
    logic [4:0] digit5;
  } mdf_out_t;

  typedef struct packed {
    logic [2:0]      mode;
    logic [AccW-1:0] v_acc;
    logic [AccW-1:0] a_acc;
  } mdf_pipe_t;

  // one shift-and-add-3 step over the bcd field and the remaining binary
  function automatic logic [AccW-1:0] dabble_step(input logic [AccW-1:0] acc);
    logic [AccW-1:0] res;
    res = acc;
    for (int k = 0; k < NumDigits; k++) begin
      if (res[BinW+4*k +: 4] >= 4'd5) begin
        res[BinW+4*k +: 4] = res[BinW+4*k +: 4] + 4'd3;
      end
    end
    return {res[AccW-2:0], 1'b0};
  endfunction

endpackage

FILE: hdl/mdf_dabble_stage.sv
module mdf_dabble_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  mdf_pkg::mdf_pipe_t data_i,
  output logic              valid_o,
  output mdf_pkg::mdf_pipe_t data_o
);
  import mdf_pkg::*;

  logic      valid_q;
  mdf_pipe_t data_d;
  mdf_pipe_t data_q;

  always_comb begin
    data_d = data_i;
    for (int s = 0; s < StepsPerStage; s++) begin
      data_d.v_acc = dabble_step(data_d.v_acc);
      data_d.a_acc = dabble_step(data_d.a_acc);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: hdl/mdf_format.sv
module mdf_format (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  mdf_pkg::mdf_pipe_t data_i,
  output logic              strobe_o,
  output mdf_pkg::mdf_out_t  result_o
);
  import mdf_pkg::*;

  logic [4:0] vd [NumDigits];
  logic [4:0] ad [NumDigits];
  logic       v_ge_10k;
  logic       v_ge_1k;
  logic       a_ge_1k;
  mdf_out_t   result_d;
  mdf_out_t   result_q;
  logic       strobe_q;

  always_comb begin
    for (int k = 0; k < NumDigits; k++) begin
      vd[k] = {1'b0, data_i.v_acc[BinW+4*k +: 4]};
      ad[k] = {1'b0, data_i.a_acc[BinW+4*k +: 4]};
    end
  end

  assign v_ge_10k = (vd[4] != 5'd0);
  assign v_ge_1k  = (vd[3] != 5'd0) || v_ge_10k;
  assign a_ge_1k  = (ad[3] != 5'd0) || (ad[4] != 5'd0);

  always_comb begin
    result_d = '0;
    unique case (data_i.mode) inside
      MODE_ONLY_V: begin
        result_d.digit0 = vd[3] + POINT_OFFSET;
        result_d.digit1 = vd[4];
        result_d.digit2 = GLYPH_V;
        result_d.digit3 = vd[0];
        result_d.digit4 = vd[1];
        result_d.digit5 = vd[2];
      end
      MODE_ONLY_A: begin
        result_d.digit0 = ad[3] + POINT_OFFSET;
        result_d.digit1 = ad[4];
        result_d.digit2 = GLYPH_A;
        result_d.digit3 = ad[0];
        result_d.digit4 = ad[1];
        result_d.digit5 = ad[2];
      end
      MODE_SET_V1, MODE_SET_V2: begin
        result_d.digit0 = GLYPH_LABEL;
        result_d.digit1 = (data_i.mode == MODE_SET_V1) ? CODE_ONE : CODE_TWO;
        result_d.digit2 = GLYPH_V;
        result_d.digit3 = vd[0];
        result_d.digit4 = vd[1];
        result_d.digit5 = vd[2];
      end
      MODE_SET_A1, MODE_SET_A2: begin
        result_d.digit0 = GLYPH_LABEL;
        result_d.digit1 = (data_i.mode == MODE_SET_A1) ? CODE_ONE : CODE_TWO;
        result_d.digit2 = GLYPH_A;
        result_d.digit3 = ad[0];
        result_d.digit4 = ad[1];
        result_d.digit5 = ad[2];
      end
      default: begin
        // dual readout, unused mode code included
        if (v_ge_10k) begin
          result_d.digit0 = vd[2];
          result_d.digit1 = vd[3] + POINT_OFFSET;
          result_d.digit2 = vd[4];
        end else if (v_ge_1k) begin
          result_d.digit0 = vd[1];
          result_d.digit1 = vd[2];
          result_d.digit2 = vd[3] + POINT_OFFSET;
        end else begin
          result_d.digit0 = vd[0];
          result_d.digit1 = vd[1];
          result_d.digit2 = vd[2];
        end
        if (a_ge_1k) begin
          result_d.digit3 = ad[1];
          result_d.digit4 = ad[2];
          result_d.digit5 = ad[3] + POINT_OFFSET;
        end else begin
          result_d.digit3 = ad[0];
          result_d.digit4 = ad[1];
          result_d.digit5 = ad[2];
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      result_q <= result_d;
    end
  end

  assign strobe_o = strobe_q;
  assign result_o = result_q;

endmodule

FILE: hdl/meter_digit_formatter.sv
// channel   direction  handshake            payload
// command   in         start high, busy low  in_i     (mode, volt_mv, amp_ma)
// result    out        strobe_o one cycle    result_o (digit0 .. digit5)
//
// one item per cycle; a result is registered through the dabble stages and then the format register
// there are four double-dabble stages of four steps each plus the format register
// busy stays low: the pipeline never holds an item back
// asynchronous active-low reset clears the valid bits only
// results cannot be stalled and leave on the strobe cycle
module meter_digit_formatter (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  mdf_pkg::mdf_in_t  in_i,
  output logic             strobe_o,
  output mdf_pkg::mdf_out_t result_o
);
  import mdf_pkg::*;

  logic      stage_valid [NumStages+1];
  mdf_pipe_t stage_data  [NumStages+1];

  assign busy = 1'b0;

  assign stage_valid[0]      = start && !busy;
  assign stage_data[0].mode  = in_i.mode;
  assign stage_data[0].v_acc = {{BcdW{1'b0}}, in_i.volt_mv};
  assign stage_data[0].a_acc = {{BcdW{1'b0}}, in_i.amp_ma};

  for (genvar g = 0; g < NumStages; g++) begin : g_dabble
    mdf_dabble_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stage_valid[g]),
      .data_i  (stage_data[g]),
      .valid_o (stage_valid[g+1]),
      .data_o  (stage_data[g+1])
    );
  end

  mdf_format u_format (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (stage_valid[NumStages]),
    .data_i   (stage_data[NumStages]),
    .strobe_o (strobe_o),
    .result_o (result_o)
  );

  a_last_stage_strobes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_valid[NumStages] |=> strobe_o)
    else $error("finished conversion did not produce a result strobe");

  a_codes_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> (result_o.digit0 <= GLYPH_LABEL) && (result_o.digit1 <= GLYPH_LABEL)
                 && (result_o.digit2 <= GLYPH_LABEL) && (result_o.digit3 <= GLYPH_LABEL)
                 && (result_o.digit4 <= GLYPH_LABEL) && (result_o.digit5 <= GLYPH_LABEL))
    else $error("display code out of range");

  a_setpoint_label: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && (result_o.digit0 == GLYPH_LABEL) |->
      ((result_o.digit1 == CODE_ONE) || (result_o.digit1 == CODE_TWO))
      && ((result_o.digit2 == GLYPH_V) || (result_o.digit2 == GLYPH_A)))
    else $error("set-point label malformed");

  a_labelled_low_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && ((result_o.digit2 == GLYPH_V) || (result_o.digit2 == GLYPH_A)) |->
      (result_o.digit3 < POINT_OFFSET) && (result_o.digit4 < POINT_OFFSET)
      && (result_o.digit5 < POINT_OFFSET))
    else $error("point shown on bottom row of a labelled display");

endmodule
